>>> design/sawc_pkg.sv
`default_nettype none
package sawc_pkg;
  typedef enum logic [1:0] {
    OP_PRELOAD = 2'd0,
    OP_READ    = 2'd1,
    OP_WRITE   = 2'd2,
    OP_MEMRD   = 2'd3
  } op_e;
  localparam int unsigned CountBits = 32;
endpackage
`default_nettype wire

>>> design/set_assoc_fifo_writeback_cache.sv
`default_nettype none
// Set-associative write-back cache, FIFO (round-robin) victim choice per set,
// write-allocate, with its backing word memory inside. One beat in gives one
// beat out. Tags, valid and dirty bits and victim pointers sit in flip-flops;
// line data and backing words sit in two single-port RAMs with registered read.
// A miss copies words one at a time through the single RAM ports. One beat is
// in flight at a time; the input is ready again the cycle after the result is
// taken. Backing memory must be preloaded before any word of it is read or
// refilled.
module set_assoc_fifo_writeback_cache #(
  parameter int unsigned ADDR_BITS   = 12,
  parameter int unsigned DATA_BITS   = 32,
  parameter int unsigned WAYS        = 4,
  parameter int unsigned SET_BITS    = 1,
  parameter int unsigned OFFSET_BITS = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           operation_i,
  input  wire logic [ADDR_BITS-1:0] address_i,
  input  wire logic [DATA_BITS-1:0] write_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [DATA_BITS-1:0]      read_data_o,
  output logic                      was_hit_o,
  output logic                      wrote_back_o,
  output logic [31:0]               hit_count_o,
  output logic [31:0]               miss_count_o
);
  import sawc_pkg::*;

  localparam int unsigned TagBits  = ADDR_BITS - SET_BITS - OFFSET_BITS;
  localparam int unsigned Sets     = 2 ** SET_BITS;
  localparam int unsigned WayBits  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned Lines    = WAYS * Sets;
  localparam int unsigned LineBits = $clog2(Lines);
  localparam int unsigned CacheAw  = LineBits + OFFSET_BITS;
  localparam int unsigned SetIw    = (SET_BITS > 0) ? SET_BITS : 1;

  // state codes
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLook  = 3'd1;  // tag compare
  localparam logic [2:0] StWbRd  = 3'd2;  // read victim word from cache RAM
  localparam logic [2:0] StWbWr  = 3'd3;  // write it to backing RAM
  localparam logic [2:0] StFlRd  = 3'd4;  // read backing word
  localparam logic [2:0] StFlWr  = 3'd5;  // write it into cache RAM
  localparam logic [2:0] StFin   = 3'd6;  // final access of the word itself
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0] state_q, state_d;

  logic [TagBits-1:0]  tag_q   [Lines];
  logic [Lines-1:0]    valid_q, dirty_q;
  logic [WayBits-1:0]  vptr_q  [Sets];
  logic [CountBits-1:0] hits_q, misses_q;

  logic [1:0]           op_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [DATA_BITS-1:0] wdata_q;
  logic [LineBits-1:0]  line_q;
  logic [OFFSET_BITS:0] cnt_q;
  logic                 wb_q, hit_q;

  // output register
  logic [DATA_BITS-1:0] rd_q;

  // address split
  logic [TagBits-1:0]     a_tag;
  logic [SetIw-1:0]       a_set;
  logic [OFFSET_BITS-1:0] a_off;
  assign a_tag = addr_q[ADDR_BITS-1 -: TagBits];
  assign a_off = addr_q[OFFSET_BITS-1:0];
  if (SET_BITS > 0) begin : g_set
    assign a_set = addr_q[OFFSET_BITS +: SetIw];
  end else begin : g_noset
    assign a_set = '0;
  end

  // hit search over the ways of the set
  logic                hit;
  logic [WayBits-1:0]  hit_way;
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid_q[LineBits'(a_set) * LineBits'(WAYS) + LineBits'(w)] &&
          tag_q[LineBits'(a_set) * LineBits'(WAYS) + LineBits'(w)] == a_tag) begin
        hit     = 1'b1;
        hit_way = WayBits'(w);
      end
    end
  end

  logic [LineBits-1:0] hit_line, vic_line;
  assign hit_line = LineBits'(a_set) * LineBits'(WAYS) + LineBits'(hit_way);
  assign vic_line = LineBits'(a_set) * LineBits'(WAYS) + LineBits'(vptr_q[a_set]);

  logic [OFFSET_BITS-1:0] cidx;
  assign cidx = cnt_q[OFFSET_BITS-1:0];

  // backing addresses of the victim word and the refill word; the victim
  // shares the set bits of the current address
  logic [ADDR_BITS-1:0] wb_addr, fl_addr;
  always_comb begin
    wb_addr = addr_q;
    wb_addr[ADDR_BITS-1 -: TagBits] = tag_q[line_q];
    wb_addr[OFFSET_BITS-1:0] = cidx;
  end
  assign fl_addr = {addr_q[ADDR_BITS-1:OFFSET_BITS], cidx};

  // RAM ports
  logic                 c_we, b_we;
  logic [CacheAw-1:0]   c_addr;
  logic [ADDR_BITS-1:0] b_addr;
  logic [DATA_BITS-1:0] c_wdata, b_wdata, c_rdata, b_rdata;

  always_comb begin
    c_we    = 1'b0;
    c_addr  = {line_q, a_off};
    c_wdata = wdata_q;
    b_we    = 1'b0;
    b_addr  = addr_q;
    b_wdata = wdata_q;
    unique case (state_q)
      StIdle: begin
        b_we = in_valid_i && operation_i == OP_PRELOAD;
        b_addr = address_i;
        b_wdata = write_data_i;
      end
      StLook: c_addr = {hit_line, a_off};
      StWbRd: c_addr = {line_q, cidx};
      StWbWr: begin
        b_we    = 1'b1;
        b_addr  = wb_addr;
        b_wdata = c_rdata;
      end
      StFlRd: b_addr = fl_addr;
      StFlWr: begin
        c_we    = 1'b1;
        c_addr  = {line_q, cidx};
        c_wdata = b_rdata;
      end
      StFin: begin
        c_we = op_q == OP_WRITE;
      end
      StOut: ;
      default: ;
    endcase
  end

  sawc_mem #(.AW(CacheAw), .DW(DATA_BITS)) u_lines (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata)
  );
  sawc_mem #(.AW(ADDR_BITS), .DW(DATA_BITS)) u_backing (
    .clk_i, .we_i(b_we), .addr_i(b_addr), .wdata_i(b_wdata), .rdata_o(b_rdata)
  );

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = state_q == StOut;
  assign read_data_o = rd_q;
  assign was_hit_o   = hit_q;
  assign wrote_back_o = wb_q;
  assign hit_count_o  = hits_q;
  assign miss_count_o = misses_q;

  logic last;
  assign last = cnt_q == (OFFSET_BITS+1)'(2 ** OFFSET_BITS - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = (operation_i == OP_PRELOAD) ? StOut : StLook;
      StLook: begin
        if (op_q == OP_MEMRD) state_d = StOut;
        else if (hit) state_d = StFin;
        else if (valid_q[vic_line] && dirty_q[vic_line]) state_d = StWbRd;
        else state_d = StFlRd;
      end
      StWbRd: state_d = StWbWr;
      StWbWr: state_d = last ? StFlRd : StWbRd;
      StFlRd: state_d = StFlWr;
      StFlWr: state_d = last ? StFin : StFlRd;
      StFin:  state_d = StOut;
      StOut:  if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      valid_q  <= '0;
      dirty_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      for (int s = 0; s < Sets; s++) vptr_q[s] <= '0;
      for (int l = 0; l < Lines; l++) tag_q[l] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: if (in_valid_i) begin
          op_q    <= operation_i;
          addr_q  <= address_i;
          wdata_q <= write_data_i;
          hit_q   <= 1'b0;
          wb_q    <= 1'b0;
          rd_q    <= '0;
          cnt_q   <= '0;
        end
        StLook: begin
          if (op_q == OP_MEMRD) begin
            rd_q <= b_rdata;
          end else if (hit) begin
            hits_q <= hits_q + 1'b1;
            hit_q  <= 1'b1;
            line_q <= hit_line;
            if (op_q == OP_WRITE) dirty_q[hit_line] <= 1'b1;
          end else begin
            misses_q <= misses_q + 1'b1;
            line_q   <= vic_line;
            if (valid_q[vic_line] && dirty_q[vic_line]) wb_q <= 1'b1;
          end
        end
        StWbWr: cnt_q <= last ? '0 : cnt_q + 1'b1;
        StFlWr: begin
          cnt_q <= cnt_q + 1'b1;
          // refill word for a read miss is taken as it passes by
          if (op_q == OP_READ && cidx == a_off) rd_q <= b_rdata;
          if (last) begin
            tag_q[line_q]   <= a_tag;
            valid_q[line_q] <= 1'b1;
            dirty_q[line_q] <= op_q == OP_WRITE;
            vptr_q[a_set]   <= (vptr_q[a_set] == WayBits'(WAYS - 1)) ? '0 :
                               vptr_q[a_set] + 1'b1;
          end
        end
        // read hit: word addressed in the tag-compare cycle
        StFin: if (op_q == OP_READ && hit_q) rd_q <= c_rdata;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/sawc_mem.sv
`default_nettype none
// Single-port synchronous RAM, registered read.
module sawc_mem #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> tb/tb_set_assoc_fifo_writeback_cache.sv
`default_nettype none
module tb_set_assoc_fifo_writeback_cache;
  timeunit 1ns;
  timeprecision 1ps;
  import sawc_pkg::*;

  // ------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // ------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OP_PRELOAD;
  logic [11:0] address_i = '0;
  logic [31:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] read_data_o;
  logic        was_hit_o;
  logic        wrote_back_o;
  logic [31:0] hit_count_o;
  logic [31:0] miss_count_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  set_assoc_fifo_writeback_cache dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .was_hit_o    (was_hit_o),
    .wrote_back_o (wrote_back_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o)
  );

  // ------------------------------------------------------------------
  // Cache shadow: backing words, line data, tags, flags, FIFO pointers
  // ------------------------------------------------------------------
  typedef struct packed {
    logic [31:0] rd;
    logic        hit;
    logic        wb;
    logic [31:0] hits;
    logic [31:0] misses;
  } cache_resp_t;

  logic [31:0] mem_word [4096];
  logic [31:0] line_data [32];
  logic [8:0]  line_tag [8];
  bit          line_vld [8];
  bit          line_drt [8];
  logic [1:0]  fifo_ptr [2];
  logic [31:0] hit_total;
  logic [31:0] miss_total;

  cache_resp_t resp_q[$];         // responses still owed by the DUT
  logic [11:0] filled_lines[$];   // line bases whose four backing words are known

  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_left = 0;
  int errors = 0;
  int beats_sent = 0;

  // Look up / allocate the line for addr, returns its index.
  task automatic find_line(input logic [11:0] addr, output int ln,
                           output bit hit, output bit wb);
    int s;
    int w;
    logic [11:0] base;
    s = addr[2];
    hit = 0;
    wb = 0;
    ln = -1;
    for (w = 0; w < 4; w++)
      if (ln < 0 && line_vld[s*4+w] && line_tag[s*4+w] == addr[11:3]) ln = s*4+w;
    if (ln >= 0) begin
      hit = 1;
      hit_total++;
      return;
    end
    miss_total++;
    ln = s*4 + fifo_ptr[s];
    if (line_vld[ln] && line_drt[ln]) begin
      base = {line_tag[ln], addr[2], 2'b00};
      for (w = 0; w < 4; w++) mem_word[base | w] = line_data[ln*4+w];
      wb = 1;
    end
    base = {addr[11:2], 2'b00};
    for (w = 0; w < 4; w++) line_data[ln*4+w] = mem_word[base | w];
    line_tag[ln] = addr[11:3];
    line_vld[ln] = 1;
    line_drt[ln] = 0;
    fifo_ptr[s] = fifo_ptr[s] + 2'd1;
  endtask

  task automatic predict_access(input op_e op, input logic [11:0] addr,
                                input logic [31:0] data);
    cache_resp_t r;
    int ln;
    bit hit;
    bit wb;
    r = '0;
    case (op)
      OP_PRELOAD: begin
        mem_word[addr] = data;
      end
      OP_READ: begin
        find_line(addr, ln, hit, wb);
        r.rd = line_data[ln*4 + addr[1:0]];
        r.hit = hit;
        r.wb = wb;
      end
      OP_WRITE: begin
        find_line(addr, ln, hit, wb);
        line_data[ln*4 + addr[1:0]] = data;
        line_drt[ln] = 1;
        r.hit = hit;
        r.wb = wb;
      end
      default: r.rd = mem_word[addr];
    endcase
    r.hits = hit_total;
    r.misses = miss_total;
    resp_q.insert(resp_q.size(), r);
  endtask

  // ------------------------------------------------------------------
  // Input driver: one beat, entered and left at a falling edge
  // ------------------------------------------------------------------
  task automatic send_beat(input op_e op, input logic [11:0] addr,
                           input logic [31:0] data);
    int gap;
    if ($urandom_range(99) < snd_idle) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    address_i <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    predict_access(op, addr, data);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  // Wait until every response is in, then let the block settle.
  task automatic drain();
    end_burst();
    while (resp_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic preload_line(input logic [11:0] base);
    int k;
    bit seen;
    for (k = 0; k < 4; k++) send_beat(OP_PRELOAD, {base[11:2], k[1:0]}, $urandom);
    seen = 0;
    foreach (filled_lines[i]) if (filled_lines[i] == {base[11:2], 2'b00}) seen = 1;
    if (!seen) filled_lines.insert(filled_lines.size(), {base[11:2], 2'b00});
  endtask

  // ------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when hold_left is set
  // ------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    cache_resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (resp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response beat rd=%h", read_data_o);
      end else begin
        want = resp_q.pop_front();
        if (want.rd !== read_data_o || want.hit !== was_hit_o ||
            want.wb !== wrote_back_o || want.hits !== hit_count_o ||
            want.misses !== miss_count_o) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp rd=%h hit=%b wb=%b hc=%0d mc=%0d",
                      " got rd=%h hit=%b wb=%b hc=%0d mc=%0d"},
                     want.rd, want.hit, want.wb, want.hits, want.misses, read_data_o,
                     was_hit_o, wrote_back_o, hit_count_o, miss_count_o);
        end
      end
    end
  end

  // Watchdog: cycles without any beat on either side
  int stuck = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= 3000) begin
      $display("tb_set_assoc_fifo_writeback_cache NOT OK");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  // Extremes of address and data, hit after miss, write then hit,
  // backing reads that bypass a dirty cached copy.
  task automatic test_directed();
    send_beat(OP_PRELOAD, 12'h000, 32'h0000_0000);
    send_beat(OP_PRELOAD, 12'h001, 32'hFFFF_FFFF);
    send_beat(OP_PRELOAD, 12'h002, 32'hA5A5_5A5A);
    send_beat(OP_PRELOAD, 12'h003, 32'h1234_5678);
    filled_lines.insert(filled_lines.size(), 12'h000);
    preload_line(12'hFFC);
    send_beat(OP_READ, 12'h000, 32'hFFFF_FFFF);      // miss
    send_beat(OP_READ, 12'h001, 32'h0);              // hit
    send_beat(OP_WRITE, 12'h002, 32'hFFFF_FFFF);     // hit, line dirty
    send_beat(OP_MEMRD, 12'h002, 32'h0);             // backing word, not cache
    send_beat(OP_PRELOAD, 12'h003, 32'hDEAD_BEEF);   // cached copy left stale
    send_beat(OP_READ, 12'h003, 32'h0);
    send_beat(OP_WRITE, 12'hFFF, 32'h0000_0000);     // set 1 miss
    send_beat(OP_READ, 12'hFFF, 32'h0);
    send_beat(OP_MEMRD, 12'hFFF, 32'h0);
    send_beat(OP_MEMRD, 12'h003, 32'h0);
    drain();
  endtask

  // Mostly accesses to lines with known backing words; some preloads.
  task automatic test_random(input int count);
    int n;
    int r;
    int idx;
    logic [11:0] a;
    logic [31:0] d;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      d = ($urandom_range(9) == 0) ? {32{$urandom_range(1) == 1}} : $urandom;
      if (r < 12 || filled_lines.size() < 3) begin
        // few tags per set so lines collide and evict
        if ($urandom_range(1))
          a = {5'd0, 4'($urandom_range(15)), 1'($urandom_range(1)), 2'b00};
        else a = 12'($urandom);
        preload_line(a);
        n += 4;
      end else if (r < 18) begin
        a = 12'($urandom);
        send_beat(OP_PRELOAD, a, d);
        n++;
      end else begin
        if ($urandom_range(3) != 0 && filled_lines.size() > 10)
          idx = filled_lines.size() - 1 - int'($urandom_range(9));
        else
          idx = int'($urandom_range(filled_lines.size() - 1));
        a = filled_lines[idx] | 12'($urandom_range(3));
        if (r < 26) send_beat(OP_MEMRD, a, d);
        else if (r < 60) send_beat(OP_WRITE, a, d);
        else send_beat(OP_READ, a, d);
        n++;
      end
    end
    drain();
  endtask

  // Output held off long enough that the input side backs up.
  task automatic test_backpressure();
    int k;
    hold_left = 300;
    for (k = 0; k < 8; k++)
      send_beat((k % 2) ? OP_WRITE : OP_READ,
                filled_lines[k % filled_lines.size()] | {10'd0, k[1:0]}, $urandom);
    drain();
  endtask

  initial begin
    for (int i = 0; i < 4096; i++) mem_word[i] = '0;
    for (int i = 0; i < 32; i++) line_data[i] = '0;
    for (int i = 0; i < 8; i++) begin
      line_tag[i] = '0;
      line_vld[i] = 0;
      line_drt[i] = 0;
    end
    fifo_ptr[0] = '0;
    fifo_ptr[1] = '0;
    hit_total = '0;
    miss_total = '0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    snd_idle = 32; rcv_idle = 66;
    test_directed();
    test_random(160);
    test_backpressure();
    snd_idle = 66; rcv_idle = 32;
    test_random(160);
    snd_idle = 0; rcv_idle = 0;
    test_random(160);

    repeat (40) @(posedge clk_i);
    if (errors == 0 && resp_q.size() == 0) begin
      $display("tb_set_assoc_fifo_writeback_cache OK");
    end else begin
      $display("tb_set_assoc_fifo_writeback_cache NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
